@@ rtl/core/clp_pkg.sv @@
// ---------------------------------------------------------------------------
// clp_pkg
// shared types and constants of the commit loop profiler
// ---------------------------------------------------------------------------
`default_nettype none
package clp_pkg;

	localparam int unsigned AddrW  = 48;
	localparam int unsigned CountW = 32;
	localparam int unsigned TotalW = 64;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CfgRangeLow  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgRangeHigh = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgRegionLen = 2'd2;

	localparam logic [AddrW-1:0] RegionLenReset = 48'd100000000;

	typedef struct packed {
		logic [AddrW-1:0] pc;
		logic [AddrW-1:0] next_pc;
		logic             final_micro_op;
		logic             user_mode;
		logic             is_control;
		logic             is_direct;
	} in_item_t;

	typedef struct packed {
		logic              counted;
		logic              block_end;
		logic              block_first_seen;
		logic              loop_found;
		logic [AddrW-1:0]  loop_target;
		logic [CountW-1:0] loop_repeat_count;
		logic              region_reached;
		logic              table_full;
	} out_item_t;

	// classified word handed from front to back
	typedef struct packed {
		logic              counted;
		logic              block_end;
		logic              loop_found;
		logic [AddrW-1:0]  blk_start;
		logic [AddrW-1:0]  blk_end;
		logic [AddrW-1:0]  target;
		logic [CountW-1:0] since;
	} task_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_WR
	} back_state_t;

endpackage
`default_nettype wire

@@ rtl/core/commit_loop_profiler_core.sv @@
// ---------------------------------------------------------------------------
// commit_loop_profiler_core
// profiles basic blocks and backward-branch loops on the commit stream
// ---------------------------------------------------------------------------
//  channel   signals                               word
//  in        in_valid / in_ready / in_data         one retired instruction
//  out       out_valid / out_ready / out_data      one profile result
//  cfg       cfg_we / cfg_index / cfg_wdata        register write, no wait
//
//  search: the time a word takes is set by the linear search over the used
//  entries of the block and loop tables (one ram read and compare per
//  entry), each table until a hit or its last used entry
//  reset: counters and table fill counts clear at once, no clearing pass
//  stalls: a two word queue lets the front accept while the back searches,
//  and an output register holds a finished word while the next is worked
// ---------------------------------------------------------------------------
`default_nettype none
module commit_loop_profiler_core #(
	parameter int unsigned BLOCK_ENTRIES = 256,
	parameter int unsigned LOOP_ENTRIES = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire clp_pkg::in_item_t           in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output clp_pkg::out_item_t               out_data,
	input  wire logic                        cfg_we,
	input  wire logic [clp_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [clp_pkg::AddrW-1:0]   cfg_wdata
);
	import clp_pkg::*;

	// configuration registers
	logic [AddrW-1:0] range_low_q;
	logic [AddrW-1:0] range_high_q;
	logic [AddrW-1:0] region_length_q;

	logic  accept;
	logic  q_full, q_empty, pop;
	task_t task_word, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= '0;
			range_high_q <= '0;
			region_length_q <= RegionLenReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgRangeLow:  range_low_q <= cfg_wdata;
				CfgRangeHigh: range_high_q <= cfg_wdata;
				CfgRegionLen: region_length_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front takes a word whenever the queue has room
	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	clp_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(in_data),
		.range_low(range_low_q), .range_high(range_high_q), .task_word(task_word)
	);

	clp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(accept), .push_word(task_word),
		.pop(pop), .full(q_full), .empty(q_empty), .head(head)
	);

	clp_back #(.BLOCK_ENTRIES(BLOCK_ENTRIES), .LOOP_ENTRIES(LOOP_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .head(head), .pop(pop),
		.region_length(region_length_q), .out_valid(out_valid),
		.out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire

@@ rtl/core/clp_ram.sv @@
// ---------------------------------------------------------------------------
// clp_ram
// generic simple dual port ram, registered read
// ---------------------------------------------------------------------------
`default_nettype none
module clp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/clp_front.sv @@
// ---------------------------------------------------------------------------
// clp_front
// filters commit words and tracks block and loop distance counters
// ---------------------------------------------------------------------------
`default_nettype none
module clp_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire clp_pkg::in_item_t         item,
	input  wire logic [clp_pkg::AddrW-1:0] range_low,
	input  wire logic [clp_pkg::AddrW-1:0] range_high,
	output clp_pkg::task_t                 task_word
);
	import clp_pkg::*;

	logic [AddrW-1:0]  block_start_q;
	logic [CountW-1:0] block_length_q;
	logic [CountW-1:0] since_q;
	logic              inwin;
	logic              cnt;
	logic [AddrW-1:0]  start_eff;
	logic [CountW-1:0] since_inc;
	logic [CountW-1:0] len_inc;

	always_comb begin
		inwin = (range_high == '0) ||
			((item.pc >= range_low) && (item.pc <= range_high));
		cnt = item.final_micro_op && inwin && item.user_mode;
		start_eff = (block_length_q == '0) ? item.pc : block_start_q;
		since_inc = (since_q == '1) ? since_q : since_q + 1'b1;
		len_inc = (block_length_q == '1) ? block_length_q : block_length_q + 1'b1;
		task_word.counted = cnt;
		task_word.block_end = cnt && item.is_control;
		task_word.loop_found = cnt && item.is_control && item.is_direct &&
			(item.next_pc < item.pc);
		task_word.blk_start = start_eff;
		task_word.blk_end = item.pc;
		task_word.target = item.next_pc;
		task_word.since = since_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_start_q <= '0;
			block_length_q <= '0;
			since_q <= '0;
		end else if (accept && cnt) begin
			block_start_q <= start_eff;
			block_length_q <= task_word.block_end ? '0 : len_inc;
			since_q <= task_word.loop_found ? '0 : since_inc;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/clp_queue.sv @@
// ---------------------------------------------------------------------------
// clp_queue
// two entry queue between front and back
// ---------------------------------------------------------------------------
`default_nettype none
module clp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire clp_pkg::task_t push_word,
	input  wire logic           pop,
	output logic                full,
	output logic                empty,
	output clp_pkg::task_t      head
);
	import clp_pkg::*;

	task_t      slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/clp_back.sv @@
// ---------------------------------------------------------------------------
// clp_back
// searches block and loop tables, updates them and forms the result
// ---------------------------------------------------------------------------
`default_nettype none
module clp_back #(
	parameter int unsigned BLOCK_ENTRIES = 256,
	parameter int unsigned LOOP_ENTRIES = 256
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_empty,
	input  wire clp_pkg::task_t            head,
	output logic                           pop,
	input  wire logic [clp_pkg::AddrW-1:0] region_length,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output clp_pkg::out_item_t             out_data
);
	import clp_pkg::*;

	localparam int unsigned BAW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
	localparam int unsigned LAW = (LOOP_ENTRIES > 1) ? $clog2(LOOP_ENTRIES) : 1;
	localparam int unsigned BUW = $clog2(BLOCK_ENTRIES + 1);
	localparam int unsigned LUW = $clog2(LOOP_ENTRIES + 1);
	localparam int unsigned IW = (BUW > LUW) ? BUW : LUW;
	localparam int unsigned BKW = 2 * AddrW;
	localparam int unsigned LKW = AddrW + CountW;

	back_state_t state_q, state_d;
	logic [IW-1:0]     idx_q;
	logic [BUW-1:0]    block_used_q;
	logic [LUW-1:0]    loop_used_q;
	logic              b_done_q, b_hit_q, l_done_q, l_hit_q;
	logic              b_rd_q, l_rd_q;
	logic [LAW-1:0]    l_hit_addr_q;
	logic [CountW-1:0] l_hit_cnt_q;
	logic [TotalW-1:0] total_q;

	logic              b_act, l_act;
	logic              b_match, l_match;
	logic              b_we, l_we;
	logic [BAW-1:0]    b_waddr;
	logic [LAW-1:0]    l_waddr;
	logic [LKW-1:0]    l_wdata;
	logic [BKW-1:0]    b_rdata;
	logic [LKW-1:0]    l_rdata;
	logic              fire;
	logic [TotalW:0]   total_sum;
	logic [TotalW-1:0] total_new;
	logic [CountW-1:0] l_inc;
	out_item_t         res;

	assign b_act = !b_done_q && (idx_q < IW'(block_used_q));
	assign l_act = !l_done_q && (idx_q < IW'(loop_used_q));
	assign b_match = b_rd_q && (b_rdata == {head.blk_start, head.blk_end});
	assign l_match = l_rd_q && (l_rdata[LKW-1:CountW] == head.target);
	assign fire = (state_q == ST_WR) && (!out_valid || out_ready);

	clp_ram #(.WIDTH(BKW), .DEPTH(BLOCK_ENTRIES)) u_block_ram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata({head.blk_start, head.blk_end}),
		.re((state_q == ST_RD) && b_act), .raddr(idx_q[BAW-1:0]), .rdata(b_rdata)
	);

	clp_ram #(.WIDTH(LKW), .DEPTH(LOOP_ENTRIES)) u_loop_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.re((state_q == ST_RD) && l_act), .raddr(idx_q[LAW-1:0]), .rdata(l_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (!q_empty) state_d = ST_RD;
			ST_RD:   state_d = (b_act || l_act) ? ST_CMP : ST_WR;
			ST_CMP:  state_d = ST_RD;
			ST_WR:   if (fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// table writes and result
	always_comb begin
		b_we = 1'b0;
		l_we = 1'b0;
		b_waddr = block_used_q[BAW-1:0];
		l_waddr = loop_used_q[LAW-1:0];
		l_inc = (l_hit_cnt_q == '1) ? l_hit_cnt_q : l_hit_cnt_q + 1'b1;
		l_wdata = {head.target, {CountW{1'b0}}};
		total_sum = {1'b0, total_q} + {{(TotalW - CountW + 1){1'b0}}, head.since};
		total_new = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
		res = '0;
		res.counted = head.counted;
		res.block_end = head.block_end;
		if (head.block_end && !b_hit_q) begin
			if (block_used_q < BUW'(BLOCK_ENTRIES)) begin
				b_we = fire;
				res.block_first_seen = 1'b1;
			end else begin
				res.table_full = 1'b1;
			end
		end
		if (head.loop_found) begin
			res.loop_found = 1'b1;
			res.loop_target = head.target;
			res.region_reached = total_new >= {{(TotalW - AddrW){1'b0}}, region_length};
			if (l_hit_q) begin
				l_we = fire;
				l_waddr = l_hit_addr_q;
				l_wdata = {head.target, l_inc};
				res.loop_repeat_count = l_inc;
			end else if (loop_used_q < LUW'(LOOP_ENTRIES)) begin
				l_we = fire;
			end else begin
				res.table_full = 1'b1;
			end
		end
		pop = fire;
	end

	always_ff @(posedge clk) begin
		if (fire) out_data <= res;
		if (state_q == ST_CMP && l_match) begin
			l_hit_addr_q <= idx_q[LAW-1:0];
			l_hit_cnt_q <= l_rdata[CountW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			block_used_q <= '0;
			loop_used_q <= '0;
			b_done_q <= 1'b1;
			b_hit_q <= 1'b0;
			l_done_q <= 1'b1;
			l_hit_q <= 1'b0;
			b_rd_q <= 1'b0;
			l_rd_q <= 1'b0;
			total_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					b_done_q <= !head.block_end;
					l_done_q <= !head.loop_found;
					b_hit_q <= 1'b0;
					l_hit_q <= 1'b0;
				end
				ST_RD: begin
					b_rd_q <= b_act;
					l_rd_q <= l_act;
				end
				ST_CMP: begin
					if (b_match) begin
						b_done_q <= 1'b1;
						b_hit_q <= 1'b1;
					end
					if (l_match) begin
						l_done_q <= 1'b1;
						l_hit_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_WR: begin
					if (fire) begin
						if (b_we) block_used_q <= block_used_q + 1'b1;
						if (l_we && !l_hit_q) loop_used_q <= loop_used_q + 1'b1;
						if (head.loop_found) total_q <= total_new;
					end
				end
				default: ;
			endcase
		end
	end

	a_block_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		block_used_q <= BUW'(BLOCK_ENTRIES)) else $error("block table overfilled");
	a_loop_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loop_used_q <= LUW'(LOOP_ENTRIES)) else $error("loop table overfilled");
	a_first_seen_closed: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.block_first_seen |-> res.block_end && !b_hit_q)
		else $error("first seen without a closing miss");
	a_pop_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("pop from empty queue");
endmodule
`default_nettype wire
